@@ hw/rtl/csw_pkg.sv @@
// ----------------------------------------------------------------------------
// csw_pkg
// Shared types, codes and defaults of the semaphore channel with wait queues.
// ----------------------------------------------------------------------------
`default_nettype none

package csw_pkg;

   localparam int THREAD_SLOTS_DEF = 16;
   localparam int TID_W            = 4;
   localparam int CAP_W            = 8;
   localparam logic [CAP_W-1:0] CAPACITY_RESET = 8'd1;

   typedef enum logic [1:0] {
      OP_SEND  = 2'd0,
      OP_WAIT  = 2'd1,
      OP_CLOSE = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_WOULD_BLOCK = 3'd1,
      ST_CLOSED      = 3'd2,
      ST_PARKED      = 3'd3,
      ST_ALREADY     = 3'd4,
      ST_OVERFLOW    = 3'd5
   } status_type;

   typedef enum logic {
      KIND_STATUS = 1'b0,
      KIND_WAKE   = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_WAKE,
      S_STATUS,
      S_CLOSE_SEL,
      S_CLOSE_RD,
      S_CLOSE_EMIT
   } state_type;

   typedef struct packed {
      op_type             operation;
      logic [TID_W-1:0]   thread_id;
      logic               block;
   } req_type;

   typedef struct packed {
      kind_type           kind;
      logic [TID_W-1:0]   target_thread;
      status_type         status;
      logic               last;
   } rsp_type;

   // Queue commands: push at tail, pop at head, seal (move head past all
   // entries, arm the backward walk), take (read walk pointer, step back).
   typedef struct packed {
      logic               push;
      logic               pop;
      logic               seal;
      logic               take;
      logic [TID_W-1:0]   id;
   } q_ctl_type;

   typedef struct packed {
      logic               empty;
      logic               full;
      logic [TID_W-1:0]   rdata;
   } q_sts_type;

endpackage

`default_nettype wire

@@ hw/rtl/channel_semaphore_wait_queues_unit.sv @@
// ----------------------------------------------------------------------------
// channel_semaphore_wait_queues_unit
// Data-less channel: token counter, closed flag and two queues of parked ids.
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake                 payload
//   req_      in          req_valid / req_ready     req_item  (csw_pkg::req_type)
//   rsp_      out         rsp_valid / rsp_ready     rsp_item  (csw_pkg::rsp_type)
//   csr_      in          csr_write_enable          csr_write_data (capacity)
//
// Sequence: send or wait run execute then status; when a parked thread is
// woken, a wake state follows the read of the queue head in execute.
// Close runs select, then a read and an emit state per parked thread, then
// status: each wake is one queue memory read followed by one output slot.
// Reset clears control state and the queue pointers; queue memories hold
// no reset value and need no clearing pass.
// A stalled rsp_ready holds the sequencer in its emit state; the output
// register keeps the pending transaction until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module channel_semaphore_wait_queues_unit #(
   parameter int THREAD_SLOTS = csw_pkg::THREAD_SLOTS_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  csw_pkg::req_type             req_item,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output csw_pkg::rsp_type             rsp_item,
   input  wire                          csr_write_enable,
   input  wire [csw_pkg::CAP_W-1:0]     csr_write_data
);
   import csw_pkg::*;

   state_type         state_ff, state_in;
   req_type           req_ff;
   status_type        status_ff, status_in;
   logic              src_ff, src_in;       // 1: sender queue, 0: receiver queue
   logic              closed_ff, closed_in;
   logic [CAP_W-1:0]  token_ff, token_in;
   logic [CAP_W-1:0]  capacity_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   q_ctl_type         rq_ctl, sq_ctl;
   q_sts_type         rq_sts, sq_sts;

   logic              emit, emit_ok;
   rsp_type           emit_data;
   logic              chan_full, chan_empty;
   logic [TID_W-1:0]  src_rdata;

   // Receiver and sender queues; at most one holds ids at any time.
   csw_id_queue #(.THREAD_SLOTS(THREAD_SLOTS)) u_rcv_q (
      .clock (clock),
      .reset (reset),
      .ctl   (rq_ctl),
      .sts   (rq_sts)
   );

   csw_id_queue #(.THREAD_SLOTS(THREAD_SLOTS)) u_snd_q (
      .clock (clock),
      .reset (reset),
      .ctl   (sq_ctl),
      .sts   (sq_sts)
   );

   // Unbuffered mode: full/empty follow the opposite queue.
   assign chan_full  = (capacity_ff == '0) ? rq_sts.empty : (token_ff == capacity_ff);
   assign chan_empty = (capacity_ff == '0) ? sq_sts.empty : (token_ff == '0);

   assign src_rdata = src_ff ? sq_sts.rdata : rq_sts.rdata;
   assign emit_ok   = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in  = state_ff;
      status_in = status_ff;
      src_in    = src_ff;
      closed_in = closed_ff;
      token_in  = token_ff;
      rq_ctl    = '0;
      sq_ctl    = '0;
      rq_ctl.id = req_ff.thread_id;
      sq_ctl.id = req_ff.thread_id;
      emit      = 1'b0;
      emit_data.kind          = KIND_STATUS;
      emit_data.target_thread = req_ff.thread_id;
      emit_data.status        = status_ff;
      emit_data.last          = 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            // Decide the transaction; queue updates land at this edge.
            state_in = S_STATUS;
            case (req_ff.operation)
               OP_SEND: begin
                  if (!req_ff.block && !closed_ff && chan_full) begin
                     status_in = ST_WOULD_BLOCK;
                  end else if (closed_ff) begin
                     status_in = ST_CLOSED;
                  end else if (!rq_sts.empty) begin
                     rq_ctl.pop = 1'b1;
                     src_in     = 1'b0;
                     status_in  = ST_OK;
                     state_in   = S_WAKE;
                  end else if (token_ff < capacity_ff) begin
                     token_in  = token_ff + 1'b1;
                     status_in = ST_OK;
                  end else if (!req_ff.block) begin
                     status_in = ST_WOULD_BLOCK;
                  end else if (sq_sts.full) begin
                     status_in = ST_OVERFLOW;
                  end else begin
                     sq_ctl.push = 1'b1;
                     status_in   = ST_PARKED;
                  end
               end
               OP_WAIT: begin
                  if (!req_ff.block && chan_empty) begin
                     status_in = closed_ff ? ST_CLOSED : ST_WOULD_BLOCK;
                  end else if (closed_ff && token_ff == '0) begin
                     status_in = ST_CLOSED;
                  end else if (!closed_ff && !sq_sts.empty) begin
                     sq_ctl.pop = 1'b1;
                     src_in     = 1'b1;
                     status_in  = ST_OK;
                     state_in   = S_WAKE;
                  end else if (token_ff != '0) begin
                     token_in  = token_ff - 1'b1;
                     status_in = ST_OK;
                  end else if (!req_ff.block) begin
                     status_in = ST_WOULD_BLOCK;
                  end else if (rq_sts.full) begin
                     status_in = ST_OVERFLOW;
                  end else begin
                     rq_ctl.push = 1'b1;
                     status_in   = ST_PARKED;
                  end
               end
               OP_CLOSE: begin
                  if (closed_ff) begin
                     status_in = ST_ALREADY;
                  end else begin
                     closed_in   = 1'b1;
                     rq_ctl.seal = 1'b1;
                     sq_ctl.seal = 1'b1;
                     status_in   = ST_OK;
                     state_in    = S_CLOSE_SEL;
                  end
               end
               default: begin
                  // Unknown code: drop without results.
                  state_in = S_IDLE;
               end
            endcase
         end

         S_WAKE: begin
            emit_data.kind          = KIND_WAKE;
            emit_data.target_thread = src_rdata;
            emit_data.status        = ST_OK;
            emit_data.last          = 1'b0;
            if (emit_ok) begin
               emit     = 1'b1;
               state_in = S_STATUS;
            end
         end

         S_STATUS: begin
            if (emit_ok) begin
               emit     = 1'b1;
               state_in = S_IDLE;
            end
         end

         // Wake in reverse dequeue order: senders newest first, then receivers.
         S_CLOSE_SEL: begin
            if (!sq_sts.empty) begin
               src_in   = 1'b1;
               state_in = S_CLOSE_RD;
            end else if (!rq_sts.empty) begin
               src_in   = 1'b0;
               state_in = S_CLOSE_RD;
            end else begin
               state_in = S_STATUS;
            end
         end

         S_CLOSE_RD: begin
            if (src_ff) begin
               sq_ctl.take = 1'b1;
            end else begin
               rq_ctl.take = 1'b1;
            end
            state_in = S_CLOSE_EMIT;
         end

         S_CLOSE_EMIT: begin
            emit_data.kind          = KIND_WAKE;
            emit_data.target_thread = src_rdata;
            emit_data.status        = ST_CLOSED;
            emit_data.last          = 1'b0;
            if (emit_ok) begin
               emit = 1'b1;
               if (src_ff ? !sq_sts.empty : !rq_sts.empty) begin
                  state_in = S_CLOSE_RD;
               end else begin
                  state_in = S_CLOSE_SEL;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         closed_ff    <= 1'b0;
         token_ff     <= '0;
         capacity_ff  <= CAPACITY_RESET;
         rsp_valid_ff <= 1'b0;
         src_ff       <= 1'b0;
      end else begin
         state_ff  <= state_in;
         closed_ff <= closed_in;
         token_ff  <= token_in;
         src_ff    <= src_in;
         if (csr_write_enable) begin
            capacity_ff <= csr_write_data;
         end
         // Hold the output transaction until taken; refill when free.
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers: no reset needed.
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      if (req_valid && req_ready) begin
         req_ff <= req_item;
      end
      if (emit) begin
         rsp_ff <= emit_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

`default_nettype wire

@@ hw/rtl/csw_id_queue.sv @@
// ----------------------------------------------------------------------------
// csw_id_queue
// Circular queue of parked thread ids in a synchronous memory, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module csw_id_queue #(
   parameter int THREAD_SLOTS = csw_pkg::THREAD_SLOTS_DEF
) (
   input  wire                 clock,
   input  wire                 reset,
   input  csw_pkg::q_ctl_type  ctl,
   output csw_pkg::q_sts_type  sts
);
   import csw_pkg::*;

   localparam int IW = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
   localparam int FW = $clog2(THREAD_SLOTS + 1);

   logic [TID_W-1:0] mem [THREAD_SLOTS];
   logic [TID_W-1:0] rdata_ff;
   logic [IW-1:0]    head_ff, head_in;
   logic [IW-1:0]    walk_ff, walk_in;
   logic [FW-1:0]    fill_ff, fill_in;
   logic [IW-1:0]    tail_idx;
   logic [FW:0]      tail_sum;

   function automatic logic [IW-1:0] step_back(input logic [IW-1:0] x);
      step_back = (x == '0) ? IW'(THREAD_SLOTS - 1) : x - 1'b1;
   endfunction

   function automatic logic [IW-1:0] step_fwd(input logic [IW-1:0] x);
      step_fwd = (x == IW'(THREAD_SLOTS - 1)) ? '0 : x + 1'b1;
   endfunction

   // head + fill stays below twice the depth: one compare and subtract
   assign tail_sum = (FW+1)'(head_ff) + (FW+1)'(fill_ff);
   assign tail_idx = (tail_sum >= (FW+1)'(THREAD_SLOTS)) ?
                     IW'(tail_sum - (FW+1)'(THREAD_SLOTS)) : IW'(tail_sum);

   always_comb begin
      head_in = head_ff;
      walk_in = walk_ff;
      fill_in = fill_ff;
      if (ctl.push) begin
         fill_in = fill_ff + 1'b1;
      end else if (ctl.pop) begin
         head_in = step_fwd(head_ff);
         fill_in = fill_ff - 1'b1;
      end else if (ctl.seal) begin
         head_in = tail_idx;
         walk_in = step_back(tail_idx);
      end else if (ctl.take) begin
         walk_in = step_back(walk_ff);
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         walk_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         walk_ff <= walk_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem[tail_idx] <= ctl.id;
      end
      if (ctl.pop) begin
         rdata_ff <= mem[head_ff];
      end else if (ctl.take) begin
         rdata_ff <= mem[walk_ff];
      end
   end

   assign sts.empty = (fill_ff == '0);
   assign sts.full  = (fill_ff == FW'(THREAD_SLOTS));
   assign sts.rdata = rdata_ff;

endmodule

`default_nettype wire

@@ hw/rtl/csw_checker.sv @@
// ----------------------------------------------------------------------------
// csw_checker
// Port-level checks of the semaphore channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module csw_checker (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   input  wire                req_ready,
   input  wire                rsp_valid,
   input  wire                rsp_ready,
   input  csw_pkg::rsp_type   rsp_item
);
   import csw_pkg::*;

   // Hold a stalled output transaction.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
      else $error("rsp transaction changed while stalled");

   // Status transaction closes each input, wakes never do.
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.last == (rsp_item.kind == KIND_STATUS)))
      else $error("last flag does not match transaction kind");

   a_wake_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.kind == KIND_WAKE |->
         rsp_item.status == ST_OK || rsp_item.status == ST_CLOSED)
      else $error("wake transaction with bad status");

   // One request at a time: ready drops after an accept.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

endmodule

bind channel_semaphore_wait_queues_unit csw_checker u_csw_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_item  (rsp_item)
);

`default_nettype wire

@@ sim/channel_semaphore_wait_queues_unit_tb.sv @@
// ----------------------------------------------------------------------------
// channel_semaphore_wait_queues_unit_tb
// Self-checking bench for the semaphore channel with wait queues. A directed
// stimulus table and then random send/wait traffic run against an in-bench
// channel predictor. The run ends with one close of a channel that holds a
// full sender queue, then directed and random traffic on the closed channel.
// ----------------------------------------------------------------------------

module channel_semaphore_wait_queues_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import csw_pkg::*;

   localparam int QUEUE_SLOTS = THREAD_SLOTS_DEF;
   // Settle wait, sized for a close with a full queue plus margin.
   localparam int SETTLE_CYCLES  = 48;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int MISMATCH_SHOWN = 10;
   localparam int PHASE_ITEMS    = 22;
   localparam int CLOSED_ITEMS   = 24;
   localparam int CAP_DRAW       = -1;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef enum logic {ROW_REQUEST, ROW_CAPACITY} row_kind_type;

   typedef struct {
      row_kind_type  kind;
      logic [1:0]    operation;
      logic [3:0]    thread_id;
      logic          block;
      int            repeats;
      bit            typed;
      status_type    status;
      logic [7:0]    capacity;
   } stim_row_type;

   // ------------------------------------------------------------------------
   // DUT ports; every input starts at a known value
   // ------------------------------------------------------------------------
   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   req_type    req_item = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   rsp_type    rsp_item;
   logic       csr_write_enable = 1'b0;
   logic [7:0] csr_write_data = '0;

   channel_semaphore_wait_queues_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_item         (req_item),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_item         (rsp_item),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // Channel predictor state: mirrors capacity, tokens, closed flag and the
   // two queues of parked thread ids.
   // ------------------------------------------------------------------------
   logic [7:0] capacity_reg = CAPACITY_RESET;
   logic [7:0] tokens_held  = '0;
   bit         chan_closed  = 1'b0;
   logic [3:0] parked_receivers[$];
   logic [3:0] parked_senders[$];

   rsp_type    step_rsp[$];       // results of the transaction just predicted
   rsp_type    expected_rsp[$];   // results still owed by the DUT, oldest first
   rsp_type    want;

   stim_row_type directed_rows[$];
   int         burst_left = 0;
   int         mismatches = 0;
   int         cycle_count = 0;
   int         ready_phase = 0;

   function automatic void add_rsp(kind_type kind, logic [3:0] tid, status_type st);
      rsp_type r;
      r.kind          = kind;
      r.target_thread = tid;
      r.status        = st;
      r.last          = 1'b0;
      step_rsp.push_back(r);
   endfunction

   // Advance the predictor by one accepted request; fill step_rsp with the
   // wakes first and the caller's status last.
   function automatic void channel_step(req_type item);
      status_type st;
      logic [3:0] woken[$];
      bit         full;
      bit         empty;
      step_rsp.delete();
      // An unbuffered channel is full with no receiver and empty with no sender
      full  = (capacity_reg == 0) ? (parked_receivers.size() == 0)
                                  : (tokens_held == capacity_reg);
      empty = (capacity_reg == 0) ? (parked_senders.size() == 0)
                                  : (tokens_held == 0);
      case (item.operation)
         OP_SEND: begin
            if (!item.block && !chan_closed && full)
               st = ST_WOULD_BLOCK;
            else if (chan_closed)
               st = ST_CLOSED;
            else if (parked_receivers.size() != 0) begin
               add_rsp(KIND_WAKE, parked_receivers.pop_front(), ST_OK);
               st = ST_OK;
            end else if (tokens_held < capacity_reg) begin
               tokens_held++;
               st = ST_OK;
            end else if (!item.block)
               st = ST_WOULD_BLOCK;
            else if (parked_senders.size() < QUEUE_SLOTS) begin
               parked_senders.push_back(item.thread_id);
               st = ST_PARKED;
            end else
               st = ST_OVERFLOW;
         end
         OP_WAIT: begin
            if (!item.block && empty)
               st = chan_closed ? ST_CLOSED : ST_WOULD_BLOCK;
            else if (chan_closed && tokens_held == 0)
               st = ST_CLOSED;
            else if (!chan_closed && parked_senders.size() != 0) begin
               add_rsp(KIND_WAKE, parked_senders.pop_front(), ST_OK);
               st = ST_OK;
            end else if (tokens_held > 0) begin
               // a closed channel still drains its tokens
               tokens_held--;
               st = ST_OK;
            end else if (!item.block)
               st = ST_WOULD_BLOCK;
            else if (parked_receivers.size() < QUEUE_SLOTS) begin
               parked_receivers.push_back(item.thread_id);
               st = ST_PARKED;
            end else
               st = ST_OVERFLOW;
         end
         OP_CLOSE: begin
            if (chan_closed)
               st = ST_ALREADY;
            else begin
               chan_closed = 1'b1;
               // dequeue receivers then senders, wake in reverse order
               woken = {parked_receivers, parked_senders};
               parked_receivers.delete();
               parked_senders.delete();
               for (int i = woken.size() - 1; i >= 0; i--)
                  add_rsp(KIND_WAKE, woken[i], ST_CLOSED);
               st = ST_OK;
            end
         end
         default: return;   // unused code: no result, no state change
      endcase
      add_rsp(KIND_STATUS, item.thread_id, st);
      step_rsp[step_rsp.size() - 1].last = 1'b1;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus table helpers
   // ------------------------------------------------------------------------
   function automatic stim_row_type req_row(logic [1:0] op, logic [3:0] tid, logic blk,
                                            int reps, status_type st);
      stim_row_type r;
      r = '{ROW_REQUEST, op, tid, blk, reps, 1'b1, st, 8'd0};
      return r;
   endfunction

   function automatic stim_row_type pred_row(logic [1:0] op, logic [3:0] tid, logic blk);
      stim_row_type r;
      r = '{ROW_REQUEST, op, tid, blk, 1, 1'b0, ST_OK, 8'd0};
      return r;
   endfunction

   function automatic stim_row_type cap_row(logic [7:0] value);
      stim_row_type r;
      r = '{ROW_CAPACITY, 2'd0, 4'd0, 1'b0, 0, 1'b0, ST_OK, value};
      return r;
   endfunction

   function automatic string rsp_text(rsp_type r);
      return $sformatf("kind=%0d thread=%0d status=%0d last=%0d",
                       r.kind, r.target_thread, r.status, r.last);
   endfunction

   function automatic void log_mismatch(string msg);
      mismatches++;
      if (mismatches <= MISMATCH_SHOWN)
         $display("[%0t] %s", $time, msg);
   endfunction

   // ------------------------------------------------------------------------
   // Sender: bursts of back-to-back transactions separated by random gaps.
   // Returns at the accepting rising edge with valid still high.
   // ------------------------------------------------------------------------
   task automatic issue_request(input req_type item, input bit typed,
                                input status_type typed_status);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_item  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      channel_step(item);
      // a typed row replaces the prediction with its single status result
      if (typed) begin
         step_rsp.delete();
         add_rsp(KIND_STATUS, item.thread_id, typed_status);
         step_rsp[0].last = 1'b1;
      end
      foreach (step_rsp[i]) expected_rsp.push_back(step_rsp[i]);
   endtask

   // Drop valid, wait until every owed result is in, then let the block
   // finish any result-less work.
   task automatic hold_off(input int settle);
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   task automatic set_capacity(input logic [7:0] value);
      hold_off(SETTLE_CYCLES);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      capacity_reg = value;
   endtask

   task automatic walk_rows(input int from_row, input int to_row);
      req_type item;
      for (int r = from_row; r < to_row; r++) begin
         if (directed_rows[r].kind == ROW_CAPACITY) begin
            set_capacity(directed_rows[r].capacity);
         end else begin
            item.operation = op_type'(directed_rows[r].operation);
            item.block     = directed_rows[r].block;
            // repeated rows step the thread id by one per transaction
            for (int k = 0; k < directed_rows[r].repeats; k++) begin
               item.thread_id = directed_rows[r].thread_id + 4'(k);
               issue_request(item, directed_rows[r].typed, directed_rows[r].status);
            end
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Receiver: stall on a repeating 4-phase pattern; one phase never
   // stalls.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      ready_phase <= ready_phase + 1;
      case (ready_phase[8:7])
         2'd0:    rsp_ready <= 1'b1;
         2'd1:    rsp_ready <= ($urandom_range(0, 3) != 0);
         2'd2:    rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= (ready_phase[2:0] < 3'd3);
      endcase
   end

   // Compare each result transaction against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp.size() == 0) begin
            log_mismatch({"unexpected transaction: ", rsp_text(rsp_item)});
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_item.kind !== want.kind ||
                rsp_item.target_thread !== want.target_thread ||
                rsp_item.status !== want.status ||
                rsp_item.last !== want.last)
               log_mismatch({"expected ", rsp_text(want), ", got ", rsp_text(rsp_item)});
         end
      end
   end

   // Watchdog: end a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   localparam int FINALE_ROW = 23;

   initial begin
      int         capacity_plan[6];
      int         sent;
      int         run_len;
      int         style;
      op_type     run_op;
      logic [1:0] op;
      req_type    item;

      capacity_plan = '{3, 0, 255, 1, CAP_DRAW, 16};

      directed_rows = '{
         // open channel, capacity 1 after reset
         req_row(OP_WAIT, 4'd0, 1'b0, 1, ST_WOULD_BLOCK),
         req_row(OP_SEND, 4'd15, 1'b0, 1, ST_OK),
         req_row(OP_SEND, 4'd1, 1'b0, 1, ST_WOULD_BLOCK),
         req_row(OP_SEND, 4'd2, 1'b1, 1, ST_PARKED),
         pred_row(OP_WAIT, 4'd3, 1'b1),
         req_row(OP_WAIT, 4'd4, 1'b0, 1, ST_OK),
         pred_row(OP_UNUSED, 4'd5, 1'b1),
         req_row(OP_WAIT, 4'd6, 1'b1, 1, ST_PARKED),
         pred_row(OP_SEND, 4'd7, 1'b0),
         // unbuffered rendezvous
         cap_row(8'd0),
         req_row(OP_SEND, 4'd8, 1'b0, 1, ST_WOULD_BLOCK),
         req_row(OP_WAIT, 4'd9, 1'b0, 1, ST_WOULD_BLOCK),
         req_row(OP_SEND, 4'd10, 1'b1, 1, ST_PARKED),
         pred_row(OP_WAIT, 4'd11, 1'b0),
         req_row(OP_WAIT, 4'd12, 1'b1, 1, ST_PARKED),
         pred_row(OP_SEND, 4'd13, 1'b0),
         // build tokens, then lower capacity below the count
         cap_row(8'd255),
         req_row(OP_SEND, 4'd14, 1'b0, 3, ST_OK),
         cap_row(8'd1),
         req_row(OP_SEND, 4'd0, 1'b0, 1, ST_WOULD_BLOCK),
         req_row(OP_SEND, 4'd1, 1'b1, 1, ST_PARKED),
         pred_row(OP_WAIT, 4'd2, 1'b0),
         req_row(OP_WAIT, 4'd3, 1'b1, 1, ST_OK),
         // finale: fill the sender queue past its limit, close, then drain
         cap_row(8'd2),
         req_row(OP_SEND, 4'd14, 1'b0, 2, ST_OK),
         req_row(OP_SEND, 4'd1, 1'b1, QUEUE_SLOTS, ST_PARKED),
         req_row(OP_SEND, 4'd5, 1'b1, 1, ST_OVERFLOW),
         pred_row(OP_CLOSE, 4'd9, 1'b1),
         req_row(OP_CLOSE, 4'd3, 1'b0, 1, ST_ALREADY),
         req_row(OP_WAIT, 4'd4, 1'b0, 1, ST_OK),
         req_row(OP_WAIT, 4'd6, 1'b1, 1, ST_OK),
         req_row(OP_WAIT, 4'd7, 1'b1, 1, ST_CLOSED),
         req_row(OP_WAIT, 4'd8, 1'b0, 1, ST_CLOSED),
         req_row(OP_SEND, 4'd11, 1'b1, 1, ST_CLOSED),
         req_row(OP_SEND, 4'd12, 1'b0, 1, ST_CLOSED),
         pred_row(OP_UNUSED, 4'd13, 1'b0)
      };

      // Hold reset, then release it at a falling edge
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      walk_rows(0, FINALE_ROW);

      // Random traffic on the open channel, one phase per capacity setting.
      // Runs of one operation with block set fill a queue toward overflow;
      // other runs release, alternate or mix in the unused code. Close is
      // held back, since the channel never reopens.
      foreach (capacity_plan[p]) begin
         set_capacity((capacity_plan[p] == CAP_DRAW) ? 8'($urandom_range(0, 255))
                                                     : 8'(capacity_plan[p]));
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            run_len = $urandom_range(1, 18);
            style   = $urandom_range(0, 3);
            run_op  = ($urandom_range(0, 1) != 0) ? OP_SEND : OP_WAIT;
            for (int k = 0; k < run_len; k++) begin
               item.thread_id = 4'($urandom);
               item.block     = 1'($urandom);
               case (style)
                  0: begin
                     item.operation = run_op;
                     item.block     = 1'b1;
                  end
                  1: item.operation = run_op;
                  2: item.operation = k[0] ? OP_WAIT : OP_SEND;
                  default: begin
                     op = 2'($urandom_range(0, 3));
                     if (op == OP_CLOSE) op = OP_UNUSED;
                     item.operation = op_type'(op);
                  end
               endcase
               issue_request(item, 1'b0, ST_OK);
               if (item.operation != OP_UNUSED) sent++;
            end
         end
      end

      // Empty both queues and the token count so the finale starts clean
      item.block = 1'b1;
      while (parked_receivers.size() != 0 || parked_senders.size() != 0 ||
             tokens_held != 0) begin
         item.operation = (parked_receivers.size() != 0) ? OP_SEND : OP_WAIT;
         item.thread_id = 4'($urandom);
         issue_request(item, 1'b0, ST_OK);
      end

      walk_rows(FINALE_ROW, directed_rows.size());

      // Random traffic on the closed channel, every code included
      for (int n = 0; n < CLOSED_ITEMS; n++) begin
         item.operation = op_type'(2'($urandom_range(0, 3)));
         item.thread_id = 4'($urandom);
         item.block     = 1'($urandom);
         issue_request(item, 1'b0, ST_OK);
      end

      hold_off(SETTLE_CYCLES);
      if (mismatches == 0 && expected_rsp.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

@@ sim.f @@
hw/rtl/csw_pkg.sv
hw/rtl/csw_id_queue.sv
hw/rtl/channel_semaphore_wait_queues_unit.sv
hw/rtl/csw_checker.sv
sim/channel_semaphore_wait_queues_unit_tb.sv
